### sv/uitfr_pkg.sv
`timescale 1ns / 1ps

package uitfr_pkg;

  // Default frame buffer depth in bytes
  localparam int unsigned BUF_DEPTH_DEF = 256;

  // Register reset values
  localparam logic [15:0] IDLE_PERIOD_RST   = 16'd999;
  localparam logic [15:0] TICK_PRESCALE_RST = 16'd7199;

  // Field widths
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned REG_W    = 16;
  localparam int unsigned CFG_IDX_W = 8;

  // Item kinds carried in in_tuser
  typedef enum logic [OPCODE_W-1:0] {
    OP_BYTE  = 2'd0,
    OP_TICK  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } opcode_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_PERIOD   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_PRESCALE = 8'd1;

endpackage

### sv/uart_idle_timeout_frame_receiver.sv
`timescale 1ns / 1ps

// Channel | Direction | Handshake           | Payload
// in_     | sink      | in_tvalid/in_tready | tuser: opcode; tdata: rx_byte, read_index
// out_    | source    | out_tvalid/out_tready | tdata: byte_count, frame_done, read_data
// cfg_    | sink      | cfg_valid/cfg_ready | cfg_index, cfg_data (16-bit register)
//
// One item per cycle while in_tready is high; one result per item, in the next cycle.
// Control state updates at the input transfer; the frame buffer memory is written
// for a byte and read for a read, its registered read port supplies the read data.
// in_tready drops only while a result waits on a low out_tready.
// Synchronous active-low reset; no clearing pass, the fill count masks stale bytes.
module uart_idle_timeout_frame_receiver #(
  parameter int unsigned BUF_DEPTH = uitfr_pkg::BUF_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [15:0]                        in_tdata,   // [7:0] rx_byte, [15:8] read_index
  input  logic [uitfr_pkg::OPCODE_W-1:0]     in_tuser,   // [1:0] opcode
  // Result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [23:0]                        out_tdata,  // [8:0] byte_count, [9] frame_done,
                                                         // [17:10] read_data, [23:18] zero
  // Configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [uitfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [uitfr_pkg::REG_W-1:0]        cfg_data
);

  localparam int unsigned AW    = $clog2(BUF_DEPTH);
  localparam int unsigned CNT_W = $clog2(BUF_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > uitfr_pkg::INDEX_W) ? CNT_W : uitfr_pkg::INDEX_W;

  // Input fields
  uitfr_pkg::opcode_t                 op;
  logic [uitfr_pkg::BYTE_W-1:0]       rx_byte;
  logic [uitfr_pkg::INDEX_W-1:0]      read_index;
  logic                               in_xfer;

  // Registers and state
  logic [uitfr_pkg::REG_W-1:0] idle_period_r;
  logic [uitfr_pkg::REG_W-1:0] tick_prescale_r;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic                        done_r, done_nxt;
  logic                        run_r, run_nxt;
  logic [uitfr_pkg::REG_W-1:0] idle_cnt_r, idle_cnt_nxt;
  logic [uitfr_pkg::REG_W-1:0] pre_cnt_r, pre_cnt_nxt;
  logic                        out_valid_r;
  logic                        rd_ok_r, rd_ok_nxt;

  // Memory interface
  logic                        mem_wr_en;
  logic                        mem_rd_en;
  logic [uitfr_pkg::BYTE_W-1:0] mem_rd_data;

  assign op         = uitfr_pkg::opcode_t'(in_tuser);
  assign rx_byte    = in_tdata[7:0];
  assign read_index = in_tdata[15:8];

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Per-item state update
  always_comb begin
    count_nxt    = count_r;
    done_nxt     = done_r;
    run_nxt      = run_r;
    idle_cnt_nxt = idle_cnt_r;
    pre_cnt_nxt  = pre_cnt_r;
    rd_ok_nxt    = 1'b0;
    mem_wr_en    = 1'b0;
    mem_rd_en    = 1'b0;
    if (in_xfer) begin
      case (op)
        uitfr_pkg::OP_BYTE: begin
          if (!done_r) begin
            if (count_r < CNT_W'(BUF_DEPTH)) begin
              idle_cnt_nxt = '0;
              if (count_r == '0) begin
                run_nxt = 1'b1;
              end
              mem_wr_en = 1'b1;
              count_nxt = count_r + CNT_W'(1);
            end else begin
              done_nxt = 1'b1;
            end
          end
        end
        uitfr_pkg::OP_TICK: begin
          if (run_r) begin
            if (pre_cnt_r != tick_prescale_r) begin
              pre_cnt_nxt = pre_cnt_r + 16'd1;
            end else begin
              pre_cnt_nxt = '0;
              if (idle_cnt_r == idle_period_r) begin
                idle_cnt_nxt = '0;
                done_nxt     = 1'b1;
                run_nxt      = 1'b0;
              end else begin
                idle_cnt_nxt = idle_cnt_r + 16'd1;
              end
            end
          end
        end
        uitfr_pkg::OP_CLEAR: begin
          count_nxt = '0;
          done_nxt  = 1'b0;
        end
        uitfr_pkg::OP_READ: begin
          mem_rd_en = 1'b1;
          rd_ok_nxt = CMP_W'(read_index) < CMP_W'(count_r);
        end
        default: begin
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      done_r      <= 1'b0;
      run_r       <= 1'b0;
      idle_cnt_r  <= '0;
      pre_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      rd_ok_r     <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      done_r     <= done_nxt;
      run_r      <= run_nxt;
      idle_cnt_r <= idle_cnt_nxt;
      pre_cnt_r  <= pre_cnt_nxt;
      if (in_xfer) begin
        out_valid_r <= 1'b1;
        rd_ok_r     <= rd_ok_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_period_r   <= uitfr_pkg::IDLE_PERIOD_RST;
      tick_prescale_r <= uitfr_pkg::TICK_PRESCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == uitfr_pkg::CFG_IDLE_PERIOD) begin
        idle_period_r <= cfg_data;
      end else if (cfg_index == uitfr_pkg::CFG_TICK_PRESCALE) begin
        tick_prescale_r <= cfg_data;
      end
    end
  end

  // Frame buffer: written at the fill count, read at the requested index
  uitfr_frame_mem #(
    .DEPTH (BUF_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (AW'(count_r)),
    .wr_data (rx_byte),
    .rd_en   (mem_rd_en),
    .rd_addr (AW'(read_index)),
    .rd_data (mem_rd_data)
  );

  // Result; count and done only move on a transfer, so they hold under stall
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0,
                       rd_ok_r ? mem_rd_data : 8'd0,
                       done_r,
                       uitfr_pkg::COUNT_W'(count_r)};

endmodule

### sv/uitfr_frame_mem.sv
`timescale 1ns / 1ps

// Frame byte store: one write port, one read port, registered read data.
module uitfr_frame_mem #(
  parameter int unsigned DEPTH = uitfr_pkg::BUF_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [AW-1:0]                  wr_addr,
  input  logic [uitfr_pkg::BYTE_W-1:0]   wr_data,
  input  logic                           rd_en,
  input  logic [AW-1:0]                  rd_addr,
  output logic [uitfr_pkg::BYTE_W-1:0]   rd_data
);

  logic [uitfr_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [uitfr_pkg::BYTE_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/uitfr_checker.sv
`timescale 1ns / 1ps

module uitfr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  logic in_xfer;
  assign in_xfer = in_tvalid && in_tready;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Every transfer yields a result on the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_tvalid)
    else $error("no result after input transfer");

  // Clear empties the frame and reopens it
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_tuser == uitfr_pkg::OP_CLEAR |=>
      out_tdata[8:0] == 9'd0 && !out_tdata[9])
    else $error("clear did not empty the frame");

  // An empty frame never returns data
  a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8:0] == 9'd0 |-> out_tdata[17:10] == 8'd0)
    else $error("read data from an empty frame");

endmodule

bind uart_idle_timeout_frame_receiver uitfr_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### sim/tb_uart_idle_timeout_frame_receiver.sv
`timescale 1ns / 1ps

module tb_uart_idle_timeout_frame_receiver;

  localparam int unsigned FRAME_DEPTH = uitfr_pkg::BUF_DEPTH_DEF;
  // Register indexes past the defined ones, which the block must ignore
  localparam logic [uitfr_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE =
    uitfr_pkg::CFG_IDX_W'(uitfr_pkg::CFG_TICK_PRESCALE + 1);
  localparam logic [uitfr_pkg::CFG_IDX_W-1:0] CFG_IDX_TOP   = '1;

  typedef struct {
    uitfr_pkg::opcode_t                 op;
    logic [uitfr_pkg::BYTE_W-1:0]       rx;
    logic [uitfr_pkg::INDEX_W-1:0]      idx;
  } rx_item_t;

  // Packed so that byte_count sits in the low bits, as on out_tdata
  typedef struct packed {
    logic [uitfr_pkg::BYTE_W-1:0]  read_data;
    logic                          frame_done;
    logic [uitfr_pkg::COUNT_W-1:0] byte_count;
  } frame_status_t;

  typedef enum {GAP_NONE, GAP_SEND, GAP_RECV, GAP_BOTH} gap_mode_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [15:0]                    in_tdata = '0;
  logic [uitfr_pkg::OPCODE_W-1:0] in_tuser = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [23:0]                    out_tdata;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [uitfr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [uitfr_pkg::REG_W-1:0]    cfg_data = '0;

  uart_idle_timeout_frame_receiver dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  rx_item_t      pending_items[$];
  frame_status_t expected_status[$];
  gap_mode_t     gap_mode = GAP_NONE;

  int items_queued    = 0;
  int items_accepted  = 0;
  int results_seen    = 0;
  int register_writes = 0;
  int error_count     = 0;
  int idle_timeouts   = 0;
  int overflow_closes = 0;

  // Frame assembler shadow state
  logic [uitfr_pkg::BYTE_W-1:0]  shadow_buf [FRAME_DEPTH];
  logic [uitfr_pkg::COUNT_W-1:0] shadow_count   = '0;
  logic                          shadow_done    = 1'b0;
  logic                          shadow_running = 1'b0;
  logic [uitfr_pkg::REG_W-1:0]   shadow_idle    = '0;
  logic [uitfr_pkg::REG_W-1:0]   shadow_presc   = '0;
  logic [uitfr_pkg::REG_W-1:0]   idle_period_reg   = uitfr_pkg::IDLE_PERIOD_RST;
  logic [uitfr_pkg::REG_W-1:0]   tick_prescale_reg = uitfr_pkg::TICK_PRESCALE_RST;

  function automatic bit roll_pct(int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  function automatic logic [7:0] rand8();
    return 8'($urandom);
  endfunction

  // Advance the shadow frame by one item and return the status it reports.
  // Clear does not wipe the buffer here: bytes past the count are never readable.
  function automatic frame_status_t advance_frame(rx_item_t it);
    frame_status_t st;
    st = '0;
    case (it.op)
      uitfr_pkg::OP_BYTE: begin
        if (!shadow_done) begin
          if (shadow_count < FRAME_DEPTH) begin
            shadow_idle = '0;
            if (shadow_count == 0) shadow_running = 1'b1;
            shadow_buf[shadow_count[uitfr_pkg::INDEX_W-1:0]] = it.rx;
            shadow_count = shadow_count + 1'b1;
          end else begin
            shadow_done = 1'b1;
            overflow_closes++;
          end
        end
      end
      uitfr_pkg::OP_TICK: begin
        if (shadow_running) begin
          if (shadow_presc != tick_prescale_reg) begin
            shadow_presc = shadow_presc + 1'b1;
          end else begin
            shadow_presc = '0;
            if (shadow_idle == idle_period_reg) begin
              shadow_idle    = '0;
              shadow_done    = 1'b1;
              shadow_running = 1'b0;
              idle_timeouts++;
            end else begin
              shadow_idle = shadow_idle + 1'b1;
            end
          end
        end
      end
      uitfr_pkg::OP_CLEAR: begin
        shadow_count = '0;
        shadow_done  = 1'b0;
      end
      default: begin
        if (it.idx < shadow_count) st.read_data = shadow_buf[it.idx];
      end
    endcase
    st.byte_count = shadow_count;
    st.frame_done = shadow_done;
    return st;
  endfunction

  // Sender: present the head of the queue, hold it until the transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) void'(pending_items.pop_front());
      if (in_tvalid && !in_tready) begin
        // stalled: keep the same item on the bus
      end else if (pending_items.size() != 0 &&
                   !roll_pct(gap_mode == GAP_SEND ? 47 : gap_mode == GAP_BOTH ? 17 : 0)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {pending_items[0].idx, pending_items[0].rx};
        in_tuser  <= pending_items[0].op;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !roll_pct(gap_mode == GAP_RECV ? 47 : gap_mode == GAP_BOTH ? 17 : 0);
    end
  end

  // Monitor: check results, then predict for the input transfer on this edge
  always @(posedge clk) begin : monitor
    frame_status_t want;
    rx_item_t      seen;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_status.size() == 0) begin
          error_count++;
          $display("%0t: result with nothing expected, actual %h", $time, out_tdata);
        end else begin
          want = expected_status.pop_front();
          if (out_tdata[8:0] !== want.byte_count) begin
            error_count++;
            $display("%0t: byte_count expected %0d actual %0d", $time, want.byte_count,
                     out_tdata[8:0]);
          end
          if (out_tdata[9] !== want.frame_done) begin
            error_count++;
            $display("%0t: frame_done expected %0d actual %0d", $time, want.frame_done,
                     out_tdata[9]);
          end
          if (out_tdata[17:10] !== want.read_data) begin
            error_count++;
            $display("%0t: read_data expected %h actual %h", $time, want.read_data,
                     out_tdata[17:10]);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        seen.op  = uitfr_pkg::opcode_t'(in_tuser);
        seen.rx  = in_tdata[7:0];
        seen.idx = in_tdata[15:8];
        expected_status.push_back(advance_frame(seen));
        items_accepted++;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == uitfr_pkg::CFG_IDLE_PERIOD) idle_period_reg = cfg_data;
        else if (cfg_index == uitfr_pkg::CFG_TICK_PRESCALE) tick_prescale_reg = cfg_data;
        register_writes++;
      end
    end
  end

  task automatic queue_item(uitfr_pkg::opcode_t op, logic [uitfr_pkg::BYTE_W-1:0] rx,
                            logic [uitfr_pkg::INDEX_W-1:0] idx);
    rx_item_t it;
    it.op  = op;
    it.rx  = rx;
    it.idx = idx;
    pending_items.push_back(it);
    items_queued++;
  endtask

  // Block until every queued item has gone through and its result is checked
  task automatic wait_drained();
    wait (items_accepted == items_queued && results_seen == items_accepted);
  endtask

  task automatic write_register(logic [uitfr_pkg::CFG_IDX_W-1:0] idx,
                                logic [uitfr_pkg::REG_W-1:0] val);
    int n;
    wait_drained();
    repeat (3) @(posedge clk);
    n = register_writes;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    wait (register_writes != n);
    cfg_valid <= 1'b0;
  endtask

  // One frame's worth of traffic: mostly clear, bytes, reads, then idle ticks
  task automatic queue_frame_burst(int expire_ticks);
    int r, n, k;
    r = $urandom_range(99, 0);
    if (r < 10) begin
      // noise
      repeat ($urandom_range(6, 1))
        queue_item(uitfr_pkg::opcode_t'($urandom_range(3, 0)), rand8(), rand8());
      return;
    end
    if (r < 18) begin
      // clear with the timer still running, then let it close the empty frame
      queue_item(uitfr_pkg::OP_CLEAR, rand8(), rand8());
      queue_item(uitfr_pkg::OP_BYTE, rand8(), rand8());
      queue_item(uitfr_pkg::OP_CLEAR, rand8(), rand8());
      repeat ($urandom_range(expire_ticks > 64 ? 8 : expire_ticks + 2, 0))
        queue_item(uitfr_pkg::OP_TICK, rand8(), rand8());
      return;
    end
    if (r < 92) queue_item(uitfr_pkg::OP_CLEAR, rand8(), rand8());
    r = $urandom_range(99, 0);
    n = r < 5 ? FRAME_DEPTH + $urandom_range(3, 0) :
        r < 20 ? $urandom_range(80, 20) : $urandom_range(16, 1);
    for (k = 0; k < n; k++) begin
      queue_item(uitfr_pkg::OP_BYTE, rand8(), rand8());
      if (n <= 80 && roll_pct(25))
        repeat ($urandom_range(2, 1)) queue_item(uitfr_pkg::OP_TICK, rand8(), rand8());
      if (roll_pct(12))
        queue_item(uitfr_pkg::OP_READ, rand8(), 8'($urandom_range(k + 1, 0)));
    end
    repeat ($urandom_range(3, 0))
      queue_item(uitfr_pkg::OP_READ, rand8(),
                 roll_pct(50) ? 8'($urandom_range(n - 1 > 255 ? 255 : n - 1, 0)) : rand8());
    repeat ($urandom_range(expire_ticks > 64 ? 8 : expire_ticks + 2, 0))
      queue_item(uitfr_pkg::OP_TICK, rand8(), rand8());
    if (roll_pct(50)) queue_item(uitfr_pkg::OP_BYTE, rand8(), rand8());
    if (roll_pct(50)) queue_item(uitfr_pkg::OP_READ, rand8(), rand8());
  endtask

  initial begin
    int p, start, expire;
    logic [uitfr_pkg::REG_W-1:0] idle_cfg, presc_cfg;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset values, stopped timer, reads past the count
    queue_item(uitfr_pkg::OP_READ, 8'h00, 8'h00);
    queue_item(uitfr_pkg::OP_READ, 8'hFF, 8'hFF);
    queue_item(uitfr_pkg::OP_TICK, 8'h00, 8'h00);
    queue_item(uitfr_pkg::OP_CLEAR, 8'h00, 8'h00);
    queue_item(uitfr_pkg::OP_BYTE, 8'h00, 8'hFF);
    queue_item(uitfr_pkg::OP_BYTE, 8'hFF, 8'h00);
    queue_item(uitfr_pkg::OP_BYTE, 8'hA5, 8'h5A);
    queue_item(uitfr_pkg::OP_READ, 8'h00, 8'h00);
    queue_item(uitfr_pkg::OP_READ, 8'h00, 8'h01);
    queue_item(uitfr_pkg::OP_READ, 8'h00, 8'h03);
    queue_item(uitfr_pkg::OP_READ, 8'hFF, 8'hFF);
    queue_item(uitfr_pkg::OP_CLEAR, 8'h00, 8'h00);
    queue_item(uitfr_pkg::OP_READ, 8'h00, 8'h00);

    // Shortest timeout: one tick closes the frame
    write_register(uitfr_pkg::CFG_IDLE_PERIOD, 16'h0000);
    write_register(uitfr_pkg::CFG_TICK_PRESCALE, 16'h0000);
    queue_item(uitfr_pkg::OP_BYTE, 8'h5A, 8'h00);
    queue_item(uitfr_pkg::OP_TICK, 8'h00, 8'h00);
    queue_item(uitfr_pkg::OP_BYTE, 8'h11, 8'h00);   // dropped while done
    queue_item(uitfr_pkg::OP_TICK, 8'h00, 8'h00);   // timer stopped
    queue_item(uitfr_pkg::OP_READ, 8'h00, 8'h00);
    queue_item(uitfr_pkg::OP_CLEAR, 8'h00, 8'h00);
    queue_item(uitfr_pkg::OP_BYTE, 8'h22, 8'h00);
    queue_item(uitfr_pkg::OP_CLEAR, 8'h00, 8'h00);  // timer keeps running
    queue_item(uitfr_pkg::OP_TICK, 8'h00, 8'h00);   // closes the empty frame
    queue_item(uitfr_pkg::OP_CLEAR, 8'h00, 8'h00);

    // Random phases, each with its own register setting and idling pattern
    for (p = 0; p < 8; p++) begin
      case (p)
        0: begin idle_cfg = 16'd0;     presc_cfg = 16'd0;     end
        1: begin idle_cfg = 16'd5;     presc_cfg = 16'd1;     end
        2: begin idle_cfg = 16'hFFFF;  presc_cfg = 16'hFFFF;  end
        3: begin idle_cfg = 16'd2;     presc_cfg = 16'd3;     end
        4: begin idle_cfg = 16'hFFFF;  presc_cfg = 16'd0;     end
        5: begin idle_cfg = 16'd0;     presc_cfg = 16'hFFFF;  end
        default: begin
          idle_cfg  = 16'($urandom_range(6, 0));
          presc_cfg = 16'($urandom_range(3, 0));
        end
      endcase
      write_register(uitfr_pkg::CFG_IDLE_PERIOD, idle_cfg);
      write_register(uitfr_pkg::CFG_TICK_PRESCALE, presc_cfg);
      if (p == 2) write_register(CFG_IDX_SPARE, 16'($urandom));
      if (p == 5) write_register(CFG_IDX_TOP, 16'($urandom));
      gap_mode = gap_mode_t'(p % 4);
      // long timeouts only need to be known as long
      expire = (idle_cfg > 16'd64 || presc_cfg > 16'd64) ? 65 :
               (int'(idle_cfg) + 1) * (int'(presc_cfg) + 1);
      start = items_queued;
      while (items_queued - start < 150) queue_frame_burst(expire);
      // hold the sender off until the phase has fully drained
      wait_drained();
    end

    // Idle counter left above a lowered period: it counts on past it
    gap_mode = GAP_NONE;
    write_register(uitfr_pkg::CFG_TICK_PRESCALE, 16'd0);
    write_register(uitfr_pkg::CFG_IDLE_PERIOD, 16'd200);
    queue_item(uitfr_pkg::OP_CLEAR, rand8(), rand8());
    queue_item(uitfr_pkg::OP_BYTE, rand8(), rand8());
    repeat (50) queue_item(uitfr_pkg::OP_TICK, rand8(), rand8());
    write_register(uitfr_pkg::CFG_IDLE_PERIOD, 16'd10);
    repeat (40) queue_item(uitfr_pkg::OP_TICK, rand8(), rand8());

    // Same for the prescaler
    write_register(uitfr_pkg::CFG_TICK_PRESCALE, 16'd100);
    write_register(uitfr_pkg::CFG_IDLE_PERIOD, 16'd0);
    queue_item(uitfr_pkg::OP_CLEAR, rand8(), rand8());
    queue_item(uitfr_pkg::OP_BYTE, rand8(), rand8());
    repeat (50) queue_item(uitfr_pkg::OP_TICK, rand8(), rand8());
    write_register(uitfr_pkg::CFG_TICK_PRESCALE, 16'd10);
    repeat (40) queue_item(uitfr_pkg::OP_TICK, rand8(), rand8());
    queue_item(uitfr_pkg::OP_READ, rand8(), 8'h00);

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Run covered %0d input transfers, %0d results, %0d register writes,",
             items_accepted, results_seen, register_writes);
    $display("with %0d idle timeouts and %0d overflow closes.", idle_timeouts,
             overflow_closes);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### sim.f
sv/uitfr_pkg.sv
sv/uitfr_frame_mem.sv
sv/uart_idle_timeout_frame_receiver.sv
sv/uitfr_checker.sv
sim/tb_uart_idle_timeout_frame_receiver.sv
